// ===== rtl/core/bit_plru_replacement_core_defines.svh =====
// Assertion macros for the bit PLRU replacement core.
// Included by the top level; expects a clock named clk and a reset named rst.
`ifndef BIT_PLRU_REPLACEMENT_CORE_DEFINES_SVH
`define BIT_PLRU_REPLACEMENT_CORE_DEFINES_SVH

// Property that must hold on every cycle out of reset.
`define BPR_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication.
`define BPR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define BPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/bpr_pkg.sv =====
// Shared types and constants for the bit PLRU replacement core.
// No dependencies; used by the controller, datapath and top level.
package bpr_pkg;

  localparam int DEF_WAYS = 8;
  localparam int DEF_SETS = 64;

  localparam int OPCODE_W = 2;
  localparam int SET_IDX_W = 6;
  localparam int WAY_IN_W = 3;
  localparam int VICTIM_W = 3;

  localparam logic [OPCODE_W-1:0] OP_TOUCH  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_INVAL  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_VICTIM = 2'd2;

  // Controller to datapath.
  typedef struct packed {
    logic sweep;    // zero one set, advance the sweep counter
    logic capture;  // latch the transaction, launch the used-bit read
    logic exec;     // apply the update, load the result if any
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic sweep_last;  // sweep counter at the last set
    logic has_result;  // captured transaction produces a result
    logic out_busy;    // output register holds a result not taken this cycle
  } status_t;

endpackage

// ===== rtl/core/bit_plru_replacement_core.sv =====
// Bit PLRU (MRU-bit) replacement core: one used bit per way for each cache set.
// Depends on bpr_pkg, bpr_ctrl, bpr_datapath and the assertion macro header.
//
// After reset the core zeroes its used-bit memory, one set per cycle, so it
// accepts no transaction until every set is cleared. After that the capture of
// a transaction reads the set from the single-port used-bit memory, and the
// execute step applies the update and loads the result register; a victim
// request whose result register is still occupied waits until it drains. Touch
// sets the way's bit, invalidate clears it, a victim request returns the lowest
// clear way, or way 0 with bits_cleared high after zeroing a fully used set.
// Out-of-range sets, opcode 3, touch/invalidate of an out-of-range way: no-ops.
`include "bit_plru_replacement_core_defines.svh"

module bit_plru_replacement_core #(
  parameter int WAYS = bpr_pkg::DEF_WAYS,
  parameter int SETS = bpr_pkg::DEF_SETS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [bpr_pkg::OPCODE_W-1:0]   opcode,
  input  logic [bpr_pkg::SET_IDX_W-1:0]  set_index,
  input  logic [bpr_pkg::WAY_IN_W-1:0]   way,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bpr_pkg::VICTIM_W-1:0]   victim_way,
  output logic                           bits_cleared
);

  bpr_pkg::cmd_t    cmd;
  bpr_pkg::status_t status;

  bpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  bpr_datapath #(
    .WAYS (WAYS),
    .SETS (SETS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .opcode       (opcode),
    .set_index    (set_index),
    .way          (way),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .victim_way   (victim_way),
    .bits_cleared (bits_cleared)
  );

  `BPR_ASSERT_ALWAYS(a_cmd_onehot, $onehot0({cmd.sweep, cmd.capture, cmd.exec}), "commands overlap")
  `BPR_ASSERT_IMPL(a_no_accept_in_sweep, cmd.sweep, !in_ready, "ready during clearing sweep")
  `BPR_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second transaction accepted early")
  `BPR_ASSERT_IMPL(a_no_result_overrun, cmd.exec && status.has_result, !status.out_busy, "result overwrites a pending one")

endmodule

// ===== rtl/core/bpr_ctrl.sv =====
// Sequencer for the bit PLRU replacement core: clearing sweep, accept, execute.
// Depends on bpr_pkg for the command and status structs.
module bpr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  bpr_pkg::status_t status,
  output bpr_pkg::cmd_t    cmd
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next  = state;
    cmd.sweep   = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    in_ready    = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.sweep = 1'b1;
        if (status.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold while a previous result still occupies the output register
        if (!(status.has_result && status.out_busy)) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/bpr_datapath.sv =====
// Used-bit memory, transaction registers, victim encoder and output register.
// Depends on bpr_pkg for field widths, opcodes and the command/status structs.
module bpr_datapath #(
  parameter int WAYS = bpr_pkg::DEF_WAYS,
  parameter int SETS = bpr_pkg::DEF_SETS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  bpr_pkg::cmd_t                  cmd,
  output bpr_pkg::status_t               status,
  input  logic [bpr_pkg::OPCODE_W-1:0]   opcode,
  input  logic [bpr_pkg::SET_IDX_W-1:0]  set_index,
  input  logic [bpr_pkg::WAY_IN_W-1:0]   way,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bpr_pkg::VICTIM_W-1:0]   victim_way,
  output logic                           bits_cleared
);

  localparam int SetW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WayW = $clog2(WAYS);

  logic [WAYS-1:0] mem [SETS];
  logic [WAYS-1:0] rdata;

  logic [bpr_pkg::OPCODE_W-1:0]  op_q;
  logic [bpr_pkg::SET_IDX_W-1:0] set_q;
  logic [bpr_pkg::WAY_IN_W-1:0]  way_q;

  logic [SetW-1:0] sweep_cnt;

  logic            set_ok;
  logic            way_ok;
  logic            is_upd;
  logic            is_victim;
  logic [WAYS-1:0] way_mask;
  logic [WAYS-1:0] upd_bits;
  logic [WayW-1:0] low_clear;
  logic            found;
  logic            we;
  logic [SetW-1:0] waddr;
  logic [WAYS-1:0] wdata;

  assign set_ok    = 32'(set_q) < SETS;
  assign way_ok    = 32'(way_q) < WAYS;
  assign is_upd    = (op_q == bpr_pkg::OP_TOUCH) || (op_q == bpr_pkg::OP_INVAL);
  assign is_victim = op_q == bpr_pkg::OP_VICTIM;
  assign way_mask  = WAYS'(1) << WayW'(way_q);
  assign upd_bits  = (op_q == bpr_pkg::OP_TOUCH) ? (rdata | way_mask) : (rdata & ~way_mask);
  assign found     = ~&rdata;

  // lowest clear bit wins
  always_comb begin
    low_clear = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (!rdata[i]) begin
        low_clear = WayW'(i);
      end
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = SetW'(set_q);
    wdata = upd_bits;
    if (cmd.sweep) begin
      we    = 1'b1;
      waddr = sweep_cnt;
      wdata = '0;
    end else if (cmd.exec && set_ok) begin
      if (is_upd && way_ok) begin
        we = 1'b1;
      end else if (is_victim && !found) begin
        // every way used: drop all bits of the set
        we    = 1'b1;
        wdata = '0;
      end
    end
  end

  assign status.sweep_last = 32'(sweep_cnt) == SETS - 1;
  assign status.has_result = set_ok && is_victim;
  assign status.out_busy   = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.capture) begin
      rdata <= mem[SetW'(set_index)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= opcode;
      set_q <= set_index;
      way_q <= way;
    end
    if (cmd.exec && status.has_result) begin
      victim_way   <= found ? bpr_pkg::VICTIM_W'(low_clear) : '0;
      bits_cleared <= !found;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.sweep) begin
        sweep_cnt <= sweep_cnt + 1'b1;
      end
      if (cmd.exec && status.has_result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== verif/bpr_victim_checker.sv =====
// Checker for the bit PLRU replacement core: watches both channels, keeps a copy
// of the per-set used bits, predicts each victim result and compares it.
// Depends on bpr_pkg for field widths, opcodes and default sizes.
module bpr_victim_checker #(
  parameter int WAYS = bpr_pkg::DEF_WAYS,
  parameter int SETS = bpr_pkg::DEF_SETS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [bpr_pkg::OPCODE_W-1:0]   opcode,
  input  logic [bpr_pkg::SET_IDX_W-1:0]  set_index,
  input  logic [bpr_pkg::WAY_IN_W-1:0]   way,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [bpr_pkg::VICTIM_W-1:0]   victim_way,
  input  logic                           bits_cleared,
  output int                             fail_count,
  output int                             pending
);

  typedef struct packed {
    logic [bpr_pkg::VICTIM_W-1:0] way;
    logic                         cleared;
  } victim_t;

  logic [WAYS-1:0] used_bits [SETS];
  victim_t         expected_victims [$];
  int              mismatches;

  function automatic void update_used_bits(logic [bpr_pkg::OPCODE_W-1:0] op,
                                           logic [bpr_pkg::SET_IDX_W-1:0] s,
                                           logic [bpr_pkg::WAY_IN_W-1:0] w);
    victim_t v;
    if (s >= SETS) return;
    case (op)
      bpr_pkg::OP_TOUCH: if (w < WAYS) used_bits[s][w] = 1'b1;
      bpr_pkg::OP_INVAL: if (w < WAYS) used_bits[s][w] = 1'b0;
      bpr_pkg::OP_VICTIM: begin
        v.way = '0;
        v.cleared = 1'b1;
        // scan downward so the lowest clear way wins
        for (int i = WAYS - 1; i >= 0; i--) begin
          if (!used_bits[s][i]) begin
            v.way = bpr_pkg::VICTIM_W'(i);
            v.cleared = 1'b0;
          end
        end
        if (v.cleared) used_bits[s] = '0;
        expected_victims.push_back(v);
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    victim_t exp_v;
    if (rst) begin
      for (int s = 0; s < SETS; s++) used_bits[s] = '0;
      expected_victims.delete();
      mismatches = 0;
    end else begin
      // a result leaving now belongs to an earlier transaction; check it first
      if (out_valid && out_ready) begin
        if (expected_victims.size() == 0) begin
          $error("victim result with none outstanding: victim_way %0d bits_cleared %0d",
                 victim_way, bits_cleared);
          mismatches++;
        end else begin
          exp_v = expected_victims.pop_front();
          if (victim_way !== exp_v.way) begin
            $error("victim_way: expected %0d, actual %0d", exp_v.way, victim_way);
            mismatches++;
          end
          if (bits_cleared !== exp_v.cleared) begin
            $error("bits_cleared: expected %0d, actual %0d", exp_v.cleared, bits_cleared);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) update_used_bits(opcode, set_index, way);
    end
    fail_count <= mismatches;
    pending <= expected_victims.size();
  end

endmodule

// ===== verif/testbench.sv =====
// Top of the bit PLRU replacement core test: clock, reset, stimulus and verdict.
// Depends on bpr_pkg, bit_plru_replacement_core and bpr_victim_checker.
module testbench;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS = 150;
  localparam logic [bpr_pkg::SET_IDX_W-1:0] HOT_SETS [4] = '{6'd0, 6'd21, 6'd42, 6'd63};
  localparam logic [bpr_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

  logic                           clk;
  logic                           rst;
  logic                           in_valid;
  logic                           in_ready;
  logic [bpr_pkg::OPCODE_W-1:0]   opcode;
  logic [bpr_pkg::SET_IDX_W-1:0]  set_index;
  logic [bpr_pkg::WAY_IN_W-1:0]   way;
  logic                           out_valid;
  logic                           out_ready;
  logic [bpr_pkg::VICTIM_W-1:0]   victim_way;
  logic                           bits_cleared;

  int fail_count;
  int pending;
  int idle_pct;
  int stall_pct;
  int quiet_cycles;

  bit_plru_replacement_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .set_index(set_index), .way(way),
    .out_valid(out_valid), .out_ready(out_ready),
    .victim_way(victim_way), .bits_cleared(bits_cleared)
  );

  bpr_victim_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .set_index(set_index), .way(way),
    .out_valid(out_valid), .out_ready(out_ready),
    .victim_way(victim_way), .bits_cleared(bits_cleared),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $error("no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL bit_plru_replacement_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Hold the transaction until accepted; drop valid only when a gap follows.
  task automatic send_item(input logic [bpr_pkg::OPCODE_W-1:0] op,
                           input logic [bpr_pkg::SET_IDX_W-1:0] s,
                           input logic [bpr_pkg::WAY_IN_W-1:0] w);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    set_index <= s;
    way <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  // Mostly hot sets so that sets fill up and get swept by victim requests.
  task automatic run_phase(input int items, input int idle, input int stall);
    int sent;
    int pick;
    int step;
    int count;
    logic [bpr_pkg::SET_IDX_W-1:0] s;
    logic [bpr_pkg::WAY_IN_W-1:0] w;
    idle_pct = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < items) begin
      s = ($urandom_range(0, 99) < 75) ? HOT_SETS[$urandom_range(0, 3)]
                                       : bpr_pkg::SET_IDX_W'($urandom_range(0, 63));
      w = bpr_pkg::WAY_IN_W'($urandom_range(0, 7));
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        // fill the set in a shuffled order, maybe leaving one way out, then ask
        step = 2 * $urandom_range(0, 3) + 1;
        count = ($urandom_range(0, 1) != 0) ? 8 : 7;
        for (int k = 0; k < count; k++) begin
          send_item(bpr_pkg::OP_TOUCH, s, bpr_pkg::WAY_IN_W'(w + k * step));
        end
        send_item(bpr_pkg::OP_VICTIM, s, bpr_pkg::WAY_IN_W'($urandom_range(0, 7)));
        sent += count + 1;
      end else if (pick < 58) begin
        send_item(bpr_pkg::OP_TOUCH, s, w);
        sent++;
      end else if (pick < 70) begin
        send_item(bpr_pkg::OP_INVAL, s, w);
        sent++;
      end else if (pick < 95) begin
        send_item(bpr_pkg::OP_VICTIM, s, w);
        sent++;
      end else begin
        send_item(OP_UNUSED, s, w);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = '0;
    set_index = '0;
    way = '0;
    idle_pct = 0;
    stall_pct = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // fresh set, way field ignored
    send_item(bpr_pkg::OP_VICTIM, 6'd0, 3'd7);
    // all but way 0 used: victim is way 0 without a sweep
    for (int k = 1; k < 8; k++) send_item(bpr_pkg::OP_TOUCH, 6'd63, bpr_pkg::WAY_IN_W'(k));
    send_item(bpr_pkg::OP_VICTIM, 6'd63, 3'd0);
    send_item(OP_UNUSED, 6'd63, 3'd0);
    send_item(bpr_pkg::OP_VICTIM, 6'd63, 3'd0);
    // fully used set: way 0 and a sweep, then the set reads empty
    send_item(bpr_pkg::OP_TOUCH, 6'd63, 3'd0);
    send_item(bpr_pkg::OP_VICTIM, 6'd63, 3'd0);
    send_item(bpr_pkg::OP_VICTIM, 6'd63, 3'd7);
    send_item(bpr_pkg::OP_TOUCH, 6'd0, 3'd0);
    send_item(bpr_pkg::OP_TOUCH, 6'd0, 3'd1);
    send_item(bpr_pkg::OP_VICTIM, 6'd0, 3'd0);
    send_item(bpr_pkg::OP_INVAL, 6'd0, 3'd0);
    send_item(bpr_pkg::OP_VICTIM, 6'd0, 3'd0);
    send_item(bpr_pkg::OP_TOUCH, 6'd0, 3'd0);
    send_item(bpr_pkg::OP_INVAL, 6'd0, 3'd1);
    send_item(bpr_pkg::OP_VICTIM, 6'd0, 3'd0);

    run_phase(PHASE_ITEMS, 0, 0);
    run_phase(PHASE_ITEMS, 56, 0);
    run_phase(PHASE_ITEMS, 0, 56);
    run_phase(PHASE_ITEMS, 22, 22);
    in_valid <= 1'b0;
    stall_pct = 0;

    do @(posedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS bit_plru_replacement_core");
    end else begin
      $display("FAIL bit_plru_replacement_core");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/bpr_pkg.sv
rtl/core/bpr_ctrl.sv
rtl/core/bpr_datapath.sv
rtl/core/bit_plru_replacement_core.sv
verif/bpr_victim_checker.sv
verif/testbench.sv
